// ===== rtl/core/websocket_frame_fragmenter_core_defines.svh =====
// Assertion macros for the frame fragmenter core.
// Included by the modules that check their own logic; no other dependencies.
`ifndef WEBSOCKET_FRAME_FRAGMENTER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_FRAGMENTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define WSF_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WSF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WSF_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define WSF_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/wsf_pkg.sv =====
// Types, codes and header builder for the frame fragmenter core.
// No dependencies.
package wsf_pkg;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } wsf_cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CTRL_LEN = 2'd1,
        ST_NO_MSG   = 2'd2
    } wsf_status_t;

    localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;
    localparam logic [7:0]  HDR_FIN         = 8'h80;
    localparam logic [7:0]  HDR_RSV1        = 8'h40;
    localparam logic [7:0]  HDR_OP_MASK     = 8'h0F;
    localparam logic [7:0]  LEN7_MASK       = 8'h7F;
    localparam logic [7:0]  LEN_CODE_16     = 8'd126;
    localparam logic [7:0]  LEN_CODE_64     = 8'd127;
    localparam logic [31:0] LEN16_MAX       = 32'd65535;
    localparam logic [31:0] CTRL_LEN_MAX    = 32'd125;
    localparam int          HDR_MAX_BYTES   = 10;
    localparam logic [3:0]  HDR_CNT_7       = 4'd2;
    localparam logic [3:0]  HDR_CNT_16      = 4'd4;
    localparam logic [3:0]  HDR_CNT_64      = 4'd10;

    typedef struct packed {
        wsf_cmd_t    command;
        logic [3:0]  opcode;
        logic [31:0] message_length;
        logic        compressed;
        logic [7:0]  data_byte;
    } wsf_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_header;
        logic        message_done;
        logic        last;
        wsf_status_t status;
    } wsf_out_t;

    typedef struct packed {
        logic [HDR_MAX_BYTES-1:0][7:0] bytes;
        logic [3:0]                    cnt;
    } wsf_hdr_t;

    // One item's worth of results: header bytes, then an optional data/error byte.
    typedef struct packed {
        wsf_hdr_t    hdr;
        logic        has_data;
        logic [7:0]  data_byte;
        logic        done;
        wsf_status_t status;
    } wsf_job_t;

    function automatic wsf_hdr_t build_header(logic [7:0] b0, logic [31:0] len);
        wsf_hdr_t h;
        h.bytes    = '0;
        h.bytes[0] = b0;
        if (len < {24'd0, LEN_CODE_16}) begin
            h.cnt      = HDR_CNT_7;
            h.bytes[1] = len[7:0] & LEN7_MASK;
        end else if (len <= LEN16_MAX) begin
            h.cnt      = HDR_CNT_16;
            h.bytes[1] = LEN_CODE_16;
            h.bytes[2] = len[15:8];
            h.bytes[3] = len[7:0];
        end else begin
            h.cnt      = HDR_CNT_64;
            h.bytes[1] = LEN_CODE_64;
            h.bytes[6] = len[31:24];
            h.bytes[7] = len[23:16];
            h.bytes[8] = len[15:8];
            h.bytes[9] = len[7:0];
        end
        return h;
    endfunction

endpackage

// ===== rtl/core/wsf_frame_ctrl.sv =====
// Message/fragment state and per-item result planning for the fragmenter.
// Depends on wsf_pkg and the core defines header.
`include "websocket_frame_fragmenter_core_defines.svh"

module wsf_frame_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  wsf_pkg::wsf_in_t in_item,
    input  logic [31:0]      max_frame_size,
    input  logic             job_ready,
    output logic             job_valid,
    output wsf_pkg::wsf_job_t job
);

    logic [31:0] msg_left_reg, msg_left_next;
    logic [31:0] frag_left_reg, frag_left_next;
    logic        first_frag_reg, first_frag_next;
    logic [3:0]  held_op_reg, held_op_next;
    logic        held_comp_reg, held_comp_next;
    logic        open_reg, open_next;

    logic        fire;
    logic        is_ctrl_in;
    logic [31:0] mx;
    logic [31:0] frag_size;
    logic [31:0] frag_cur;
    logic [7:0]  b0;

    assign job_valid = in_valid;
    assign fire      = in_valid && job_ready;
    assign is_ctrl_in = in_item.opcode[3];

    assign mx        = (max_frame_size == 32'd0) ? 32'd1 : max_frame_size;
    assign frag_size = (!held_op_reg[3] && msg_left_reg > mx) ? mx : msg_left_reg;
    assign frag_cur  = (frag_left_reg == 32'd0) ? frag_size : frag_left_reg;
    assign b0 = ((frag_size == msg_left_reg) ? wsf_pkg::HDR_FIN : 8'h00)
              | ((first_frag_reg && held_comp_reg) ? wsf_pkg::HDR_RSV1 : 8'h00)
              | (first_frag_reg ? ({4'h0, held_op_reg} & wsf_pkg::HDR_OP_MASK) : 8'h00);

    always_comb begin
        msg_left_next   = msg_left_reg;
        frag_left_next  = frag_left_reg;
        first_frag_next = first_frag_reg;
        held_op_next    = held_op_reg;
        held_comp_next  = held_comp_reg;
        open_next       = open_reg;

        job           = '0;
        job.status    = wsf_pkg::ST_OK;
        job.data_byte = in_item.data_byte;

        if (in_item.command == wsf_pkg::CMD_START) begin
            open_next       = 1'b0;
            msg_left_next   = 32'd0;
            frag_left_next  = 32'd0;
            first_frag_next = 1'b1;
            if (is_ctrl_in && in_item.message_length > wsf_pkg::CTRL_LEN_MAX) begin
                job.has_data  = 1'b1;
                job.data_byte = 8'h00;
                job.status    = wsf_pkg::ST_CTRL_LEN;
            end else if (in_item.message_length == 32'd0) begin
                job.hdr  = wsf_pkg::build_header(wsf_pkg::HDR_FIN | {4'h0, in_item.opcode},
                                                 32'd0);
                job.done = 1'b1;
            end else begin
                held_op_next   = in_item.opcode;
                held_comp_next = is_ctrl_in ? 1'b0 : in_item.compressed;
                msg_left_next  = in_item.message_length;
                open_next      = 1'b1;
            end
        end else if (!open_reg || msg_left_reg == 32'd0) begin
            job.has_data  = 1'b1;
            job.data_byte = 8'h00;
            job.status    = wsf_pkg::ST_NO_MSG;
        end else begin
            if (frag_left_reg == 32'd0) begin
                job.hdr         = wsf_pkg::build_header(b0, frag_size);
                first_frag_next = 1'b0;
            end
            job.has_data   = 1'b1;
            frag_left_next = frag_cur - 32'd1;
            msg_left_next  = msg_left_reg - 32'd1;
            if (msg_left_reg == 32'd1) begin
                job.done        = 1'b1;
                open_next       = 1'b0;
                first_frag_next = 1'b1;
                frag_left_next  = 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_left_reg   <= 32'd0;
            frag_left_reg  <= 32'd0;
            first_frag_reg <= 1'b1;
            held_op_reg    <= 4'd0;
            held_comp_reg  <= 1'b0;
            open_reg       <= 1'b0;
        end else if (fire) begin
            msg_left_reg   <= msg_left_next;
            frag_left_reg  <= frag_left_next;
            first_frag_reg <= first_frag_next;
            held_op_reg    <= held_op_next;
            held_comp_reg  <= held_comp_next;
            open_reg       <= open_next;
        end
    end

    `WSF_ASSERT_IMPL(a_open_has_bytes, aclk, aresetn, open_reg, msg_left_reg != 32'd0)
    `WSF_ASSERT_IMPL(a_frag_within_msg, aclk, aresetn, 1'b1, frag_left_reg <= msg_left_reg)
    `WSF_ASSERT_IMPL(a_closed_no_frag, aclk, aresetn, !open_reg, frag_left_reg == 32'd0)

endmodule

// ===== rtl/core/wsf_byte_emitter.sv =====
// Serializes one planned job into result items through the output register.
// Depends on wsf_pkg and the core defines header.
`include "websocket_frame_fragmenter_core_defines.svh"

module wsf_byte_emitter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    input  wsf_pkg::wsf_job_t job,
    output logic              job_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output wsf_pkg::wsf_out_t m_item
);

    wsf_pkg::wsf_job_t job_reg;
    logic              job_valid_reg, job_valid_next;
    logic [3:0]        idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    wsf_pkg::wsf_out_t m_item_reg, m_item_next;

    logic [3:0] total;
    logic       cur_last;
    logic       out_free;
    logic       emit;
    logic       finish;
    logic       load;

    assign total    = job_reg.hdr.cnt + {3'b000, job_reg.has_data};
    assign cur_last = (idx_reg == total - 4'd1);
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = job_valid_reg && (total != 4'd0) && out_free;
    assign finish   = job_valid_reg && ((total == 4'd0) || (emit && cur_last));
    assign job_ready = !job_valid_reg || finish;
    assign load     = job_valid && job_ready;

    always_comb begin
        job_valid_next = job_valid_reg;
        if (load) begin
            job_valid_next = 1'b1;
        end else if (finish) begin
            job_valid_next = 1'b0;
        end
        idx_next = idx_reg;
        if (load) begin
            idx_next = 4'd0;
        end else if (emit) begin
            idx_next = idx_reg + 4'd1;
        end
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_comb begin
        m_item_next              = m_item_reg;
        m_item_next.last         = cur_last;
        m_item_next.message_done = cur_last && job_reg.done;
        if (idx_reg < job_reg.hdr.cnt) begin
            m_item_next.out_byte  = job_reg.hdr.bytes[idx_reg];
            m_item_next.is_header = 1'b1;
            m_item_next.status    = wsf_pkg::ST_OK;
        end else begin
            m_item_next.out_byte  = job_reg.data_byte;
            m_item_next.is_header = 1'b0;
            m_item_next.status    = job_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job;
        end
        if (emit) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `WSF_ASSERT_IMPL(a_idx_in_job, aclk, aresetn, job_valid_reg,
        idx_reg < total || total == 4'd0)
    `WSF_ASSERT_IMPL(a_err_single, aclk, aresetn,
        m_valid_reg && m_item_reg.status != wsf_pkg::ST_OK,
        m_item_reg.last && !m_item_reg.is_header)
    `WSF_ASSERT_NEXT(a_load_restarts, aclk, aresetn, load,
        job_valid_reg && idx_reg == 4'd0)

endmodule

// ===== rtl/core/websocket_frame_fragmenter_core.sv =====
// An accepted item passes the input register, the job register and the output register.
// Throughput: one item per cycle while each causes one result and m_ready is high; an item
// that opens a fragment holds the byte emitter for its header bytes plus its data byte.
// Emitter sets the rate: one result byte per cycle through the output register while m_ready is high.
// Reset: aresetn synchronous active low; clears the control state (not the data registers), max_frame_size = 65536.
module websocket_frame_fragmenter_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wsf_pkg::wsf_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output wsf_pkg::wsf_out_t m_item,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data
);

    logic              in_valid_reg, in_valid_next;
    wsf_pkg::wsf_in_t  in_item_reg;
    logic [31:0]       max_frame_reg;
    logic              job_valid;
    logic              job_ready;
    wsf_pkg::wsf_job_t job;
    logic              s_fire;

    assign s_ready = !in_valid_reg || job_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (job_ready) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            max_frame_reg <= wsf_pkg::MAX_FRAME_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                max_frame_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
    end

    wsf_frame_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (in_valid_reg),
        .in_item        (in_item_reg),
        .max_frame_size (max_frame_reg),
        .job_ready      (job_ready),
        .job_valid      (job_valid),
        .job            (job)
    );

    wsf_byte_emitter u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
